// ----- design/page_frame_bitmap_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// page_frame_bitmap_engine_core_macros
// Assertion helpers for the page frame bitmap engine.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ENGINE_CORE_MACROS_SVH
`define PAGE_FRAME_BITMAP_ENGINE_CORE_MACROS_SVH
// implication checked on every clock, quiet in reset
`define PFB_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// next-cycle implication
`define PFB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// ----- design/pfb_pkg.sv -----
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants of the page frame bitmap engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pfb_pkg;
   localparam int NUM_ZONES  = 4;
   localparam int ZONE_BITS  = 32768;
   localparam int ZONE_WORDS = (ZONE_BITS + 63) / 64;
   localparam int ZW         = $clog2(NUM_ZONES) > 0 ? $clog2(NUM_ZONES) : 1;
   localparam int CW         = $clog2(NUM_ZONES + 1);
   localparam int BW         = $clog2(ZONE_BITS + 1);
   localparam int AW         = $clog2(NUM_ZONES * ZONE_WORDS);
   localparam int FW         = 40;

   typedef enum logic [3:0] {
      REQ_CLEAR = 4'd0, REQ_ADD = 4'd1, REQ_LOAD = 4'd2, REQ_SET = 4'd3,
      REQ_CLR = 4'd4, REQ_TEST = 4'd5, REQ_FRAME = 4'd6, REQ_NEXT = 4'd7,
      REQ_REWIND = 4'd8
   } req_code_type;

   // memory port requests from the sequencer
   typedef struct packed {
      logic          rd;
      logic          wr;
      logic [AW-1:0] addr;
      logic [63:0]   wdata;
   } mem_req_type;
endpackage
`default_nettype wire

// ----- design/pfb_word_ram.sv -----
// ----------------------------------------------------------------------------
// pfb_word_ram
// Bitmap word store, one port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pfb_word_ram (
   input  wire logic                clock,
   input  wire pfb_pkg::mem_req_type mreq,
   output logic [63:0]               rdata_ff
);
   import pfb_pkg::*;
   logic [63:0] mem [NUM_ZONES*ZONE_WORDS];
   always_ff @(posedge clock) begin
      if (mreq.wr) mem[mreq.addr] <= mreq.wdata;
      if (mreq.rd) rdata_ff <= mem[mreq.addr];
   end
endmodule
`default_nettype wire

// ----- design/page_frame_bitmap_engine_core.sv -----
// ----------------------------------------------------------------------------
// page_frame_bitmap_engine_core
// Zoned page frame bitmap with a next-set-bit iterator, run by a sequencer
// over one shared 40-bit compare/subtract unit and a single-port word RAM.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  request | req_type frame zone_end_frame word_*    | start & !busy
//  result  | rsp_found rsp_bit_value rsp_next_frame  | rsp_strobe, one cycle
//          | rsp_end_of_map rsp_table_full           |
//
// Clear, add, load and rewind go from the accepting edge to S_DONE. Lookups walk
// zones newest first, a bit count then an offset compare per zone (S_ZCNT,
// S_ZCMP); a hit then reads and updates the word (S_RD, S_RDW, S_UPD).
// Next set: S_NZ per zone and compare, read, scan per bitmap word, then S_DONE.
// Reset clears state, strobe, zone count and iterator only; RAM has no clearing pass.
// The receiver cannot stall: busy drops in the strobe cycle.
`default_nettype none
`include "page_frame_bitmap_engine_core_macros.svh"
module page_frame_bitmap_engine_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_type,
   input  wire logic [39:0] req_frame,
   input  wire logic [39:0] req_zone_end_frame,
   input  wire logic [8:0]  req_word_index,
   input  wire logic [63:0] req_word_data,
   output logic             rsp_strobe,
   output logic             rsp_found,
   output logic             rsp_bit_value,
   output logic [39:0]      rsp_next_frame,
   output logic             rsp_end_of_map,
   output logic             rsp_table_full
);
   import pfb_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ZCNT, S_ZCMP, S_RD, S_RDW, S_UPD, S_NZ, S_NCMP, S_NRD,
      S_NRDW, S_DONE
   } state_type;

   state_type state_ff;
   logic [3:0]    op_ff;
   logic [FW-1:0] frame_ff;
   logic [FW-1:0] zs_ff [NUM_ZONES];
   logic [FW-1:0] ze_ff [NUM_ZONES];
   logic [CW-1:0] count_ff;
   logic [ZW-1:0] iz_ff;       // iterator walk position
   logic [BW-1:0] ib_ff;       // iterator next bit
   logic [CW-1:0] k_ff;        // lookup walk, counts down
   logic [BW-1:0] n_ff;        // current zone bit count
   logic [BW-1:0] bit_ff;      // matched bit
   logic [ZW-1:0] slot_ff;
   logic          found_ff, bitv_ff, eom_ff, full_ff;
   logic [FW-1:0] nextf_ff;
   mem_req_type   mreq;
   logic [63:0]   rdata;

   // shared 40-bit subtract unit
   logic [FW-1:0] sub_a, sub_b;
   logic [FW:0]   sub_d;
   assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
   logic sub_lt;
   assign sub_lt = sub_d[FW];

   pfb_word_ram u_ram (.clock(clock), .mreq(mreq), .rdata_ff(rdata));

   logic [ZW-1:0] kslot;
   assign kslot = ZW'(k_ff - CW'(1));
   logic [ZW-1:0] nslot;
   assign nslot = ZW'(count_ff - CW'(1) - CW'(iz_ff));

   // count of a zone from end-start difference
   function automatic logic [BW-1:0] zcount(logic [FW:0] d);
      if (d[FW] || d == '0) return '0;
      if (d[FW-1:0] > FW'(ZONE_BITS)) return BW'(ZONE_BITS);
      return BW'(d[FW-1:0]);
   endfunction

   // masked word and first set bit
   logic [63:0] wmask;
   logic [5:0]  fpos;
   logic        fany;
   always_comb begin
      wmask = rdata & ({64{1'b1}} << ib_ff[5:0]);
      fpos = '0;
      fany = |wmask;
      for (int i = 63; i >= 0; i--) if (wmask[i]) fpos = 6'(i);
   end
   logic [BW-1:0] scan_pos;
   assign scan_pos = {ib_ff[BW-1:6], fpos};

   always_comb begin
      sub_a = frame_ff;
      sub_b = '0;
      unique case (state_ff)
         S_ZCNT: begin sub_a = ze_ff[kslot]; sub_b = zs_ff[kslot]; end
         S_ZCMP: begin sub_a = frame_ff; sub_b = zs_ff[kslot]; end
         S_NZ:   begin sub_a = ze_ff[nslot]; sub_b = zs_ff[nslot]; end
         default: ;
      endcase
   end

   always_comb begin
      mreq = '0;
      mreq.addr = AW'(slot_ff) * AW'(ZONE_WORDS) + AW'(bit_ff[BW-1:6]);
      unique case (state_ff)
         S_RD: mreq.rd = 1'b1;
         S_UPD: begin
            mreq.wr = (op_ff == REQ_SET) || (op_ff == REQ_CLR);
            mreq.wdata = (op_ff == REQ_SET) ? (rdata | (64'd1 << bit_ff[5:0]))
                                            : (rdata & ~(64'd1 << bit_ff[5:0]));
         end
         S_NRD: begin
            mreq.rd = 1'b1;
            mreq.addr = AW'(nslot) * AW'(ZONE_WORDS) + AW'(ib_ff[BW-1:6]);
         end
         S_IDLE: begin
            mreq.wr = start && (req_type == REQ_LOAD) && (count_ff != '0) &&
                      (int'(req_word_index) < ZONE_WORDS);
            mreq.addr = AW'(count_ff - CW'(1)) * AW'(ZONE_WORDS) + AW'(req_word_index);
            mreq.wdata = req_word_data;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         iz_ff <= '0;
         ib_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               op_ff <= req_type; frame_ff <= req_frame;
               found_ff <= 1'b0; bitv_ff <= 1'b0; eom_ff <= 1'b0; full_ff <= 1'b0;
               nextf_ff <= '0;
               k_ff <= count_ff;
               state_ff <= S_DONE;
               unique case (req_type)
                  REQ_CLEAR: begin count_ff <= '0; iz_ff <= '0; ib_ff <= '0; end
                  REQ_ADD: if (count_ff >= CW'(NUM_ZONES)) full_ff <= 1'b1;
                     else begin
                        zs_ff[ZW'(count_ff)] <= req_frame;
                        ze_ff[ZW'(count_ff)] <= req_zone_end_frame;
                        count_ff <= count_ff + CW'(1);
                        iz_ff <= '0; ib_ff <= '0;
                     end
                  REQ_SET, REQ_CLR, REQ_TEST, REQ_FRAME: begin
                     if (req_type == REQ_FRAME) begin iz_ff <= '0; ib_ff <= '0; end
                     state_ff <= (count_ff == '0) ? S_DONE : S_ZCNT;
                  end
                  REQ_NEXT: state_ff <= S_NZ;
                  REQ_REWIND: begin iz_ff <= '0; ib_ff <= '0; end
                  default: ;
               endcase
            end
            S_ZCNT: begin n_ff <= zcount(sub_d); state_ff <= S_ZCMP; end
            S_ZCMP: begin
               if (!sub_lt && sub_d[FW-1:0] < FW'(n_ff)) begin
                  bit_ff <= BW'(sub_d[FW-1:0]); slot_ff <= kslot; state_ff <= S_RD;
               end else begin
                  k_ff <= k_ff - CW'(1);
                  state_ff <= (k_ff == CW'(1)) ? S_DONE : S_ZCNT;
               end
            end
            S_RD: state_ff <= S_RDW;
            S_RDW: state_ff <= S_UPD;
            S_UPD: begin
               found_ff <= 1'b1;
               bitv_ff <= (op_ff == REQ_SET) ? 1'b1 :
                          (op_ff == REQ_CLR) ? 1'b0 : rdata[bit_ff[5:0]];
               state_ff <= S_DONE;
            end
            S_NZ: begin
               if (CW'(iz_ff) >= count_ff) begin
                  iz_ff <= '0; ib_ff <= '0; eom_ff <= 1'b1; state_ff <= S_DONE;
               end else begin
                  n_ff <= zcount(sub_d); state_ff <= S_NCMP;
               end
            end
            S_NCMP: begin
               if (ib_ff >= n_ff) begin
                  ib_ff <= '0;
                  if (CW'(iz_ff) + CW'(1) >= count_ff) begin
                     iz_ff <= '0; eom_ff <= 1'b1; state_ff <= S_DONE;
                  end else begin
                     iz_ff <= iz_ff + ZW'(1); state_ff <= S_NZ;
                  end
               end else state_ff <= S_NRD;
            end
            S_NRD: state_ff <= S_NRDW;
            S_NRDW: begin
               if (fany && scan_pos < n_ff) begin
                  ib_ff <= scan_pos + BW'(1);
                  nextf_ff <= zs_ff[nslot] + FW'(scan_pos);
                  state_ff <= S_DONE;
               end else begin
                  ib_ff <= {ib_ff[BW-1:6] + (BW-6)'(1), 6'd0};
                  state_ff <= S_NCMP;
               end
            end
            S_DONE: begin rsp_strobe <= 1'b1; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_found = found_ff;
   assign rsp_bit_value = bitv_ff;
   assign rsp_next_frame = nextf_ff;
   assign rsp_end_of_map = eom_ff;
   assign rsp_table_full = full_ff;

   `PFB_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, count_ff <= CW'(NUM_ZONES), "zone count over")
   `PFB_ASSERT_IMP(a_bit_found, clock, reset, rsp_strobe && rsp_bit_value,
                   rsp_found, "bit w/o found")
   `PFB_ASSERT_NEXT(a_strobe_idle, clock, reset, rsp_strobe, !rsp_strobe, "double strobe")
   `PFB_ASSERT_IMP(a_eom_zero, clock, reset, rsp_strobe && rsp_end_of_map,
                   rsp_next_frame == '0, "eom with frame")
endmodule
`default_nettype wire
